// ===== src/fenwick_tree_range_sum_assert.svh =====
// Assertion macros for the Fenwick tree range-sum block.
// Used by the top level; no other dependencies.
`ifndef FENWICK_TREE_RANGE_SUM_ASSERT_SVH
`define FENWICK_TREE_RANGE_SUM_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define FTRS_ASSERT(label, clk_i, rstn_i, prop) \
    label: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
        else $error("fenwick tree assertion failed");
// Checked in every cycle, reset included.
`define FTRS_ASSERT_ALWAYS(label, clk_i, prop) \
    label: assert property (@(posedge clk_i) prop) \
        else $error("fenwick tree assertion failed");
`else
`define FTRS_ASSERT(label, clk_i, rstn_i, prop)
`define FTRS_ASSERT_ALWAYS(label, clk_i, prop)
`endif

`endif

// ===== src/ftrs_pkg.sv =====
// Shared types and constants for the Fenwick tree range-sum block.
// No dependencies.
package ftrs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 10;

    // request kinds carried on req_type
    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_SUM = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef enum logic {
        OP_ADD,
        OP_SUB
    } alu_op_t;

endpackage

// ===== src/ftrs_ram.sv =====
// Simple dual-port RAM with registered read data, one write port, one read port.
// Depends on ftrs_pkg.
module ftrs_ram #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  ftrs_pkg::data_t      wdata,
    input  logic [AW-1:0]        raddr,
    output ftrs_pkg::data_t      rdata
);

    ftrs_pkg::data_t mem [DEPTH];
    ftrs_pkg::data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ftrs_addsub.sv =====
// Shared 32-bit add/subtract unit, wrapping modulo 2^32.
// Depends on ftrs_pkg.
module ftrs_addsub (
    input  ftrs_pkg::data_t   a,
    input  ftrs_pkg::data_t   b,
    input  ftrs_pkg::alu_op_t op,
    output ftrs_pkg::data_t   y
);

    always_comb
    begin
        case (op)
            ftrs_pkg::OP_SUB: y = a - b;
            default:          y = a + b;
        endcase
    end

endmodule

// ===== src/ftrs_seq.sv =====
// Sequencer for the Fenwick tree: clearing pass, update walk, two prefix walks.
// Depends on ftrs_pkg and ftrs_addsub; drives the two RAMs in the top level.
module ftrs_seq #(
    parameter int ELEMENTS = 1024,
    localparam int AW = $clog2(ELEMENTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  ftrs_pkg::idx_t       index,
    input  ftrs_pkg::idx_t       index_high,
    input  ftrs_pkg::data_t      new_value,
    output logic                 done,
    output ftrs_pkg::data_t      range_sum,
    output logic                 ev_we,
    output logic [AW-1:0]        ev_waddr,
    output ftrs_pkg::data_t      ev_wdata,
    output logic [AW-1:0]        ev_raddr,
    input  ftrs_pkg::data_t      ev_rdata,
    output logic                 ps_we,
    output logic [AW-1:0]        ps_waddr,
    output ftrs_pkg::data_t      ps_wdata,
    output logic [AW-1:0]        ps_raddr,
    input  ftrs_pkg::data_t      ps_rdata
);

    localparam int KW = $clog2(ELEMENTS + 1);
    localparam int CW = (KW > ftrs_pkg::IDX_W + 1) ? KW : ftrs_pkg::IDX_W + 1;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EV_RD   = 4'd2;
    localparam logic [3:0] S_EV_DIFF = 4'd3;
    localparam logic [3:0] S_PS_RD   = 4'd4;
    localparam logic [3:0] S_PS_UPD  = 4'd5;
    localparam logic [3:0] S_Q_RD    = 4'd6;
    localparam logic [3:0] S_Q_ACC   = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic                  phase_reg, phase_next;
    logic                  done_reg, done_next;
    ftrs_pkg::idx_t        lo_reg, lo_next;
    ftrs_pkg::data_t       val_reg, val_next;
    ftrs_pkg::data_t       acc_reg, acc_next;
    ftrs_pkg::data_t       sum_reg, sum_next;

    logic [CW-1:0]         hi_end, hi_sat, lo_end, lo_sat;
    logic                  set_in_range;
    logic [KW-1:0]         k_lowbit, k_minus1, k_down;
    logic [KW:0]           k_up;
    logic                  up_done;

    ftrs_pkg::data_t       alu_a, alu_b, alu_y;
    ftrs_pkg::alu_op_t     alu_op;

    ftrs_addsub u_addsub (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    // Prefix ends saturate at the full array.
    assign hi_end = CW'(index_high) + CW'(1);
    assign hi_sat = (hi_end > CW'(ELEMENTS)) ? CW'(ELEMENTS) : hi_end;
    assign lo_end = CW'(lo_reg);
    assign lo_sat = (lo_end > CW'(ELEMENTS)) ? CW'(ELEMENTS) : lo_end;
    assign set_in_range = CW'(index) < CW'(ELEMENTS);

    assign k_lowbit = k_reg & (~k_reg + KW'(1));
    assign k_minus1 = k_reg - KW'(1);
    assign k_down   = k_reg & k_minus1;
    assign k_up     = {1'b0, k_reg} + {1'b0, k_lowbit};
    assign up_done  = k_up > (KW + 1)'(ELEMENTS);

    always_comb
    begin
        alu_a  = acc_reg;
        alu_b  = ps_rdata;
        alu_op = ftrs_pkg::OP_ADD;
        unique case (state_reg)
            S_EV_DIFF:
            begin
                alu_a  = val_reg;
                alu_b  = ev_rdata;
                alu_op = ftrs_pkg::OP_SUB;
            end
            S_PS_UPD:
            begin
                alu_a  = ps_rdata;
                alu_b  = acc_reg;
                alu_op = ftrs_pkg::OP_ADD;
            end
            S_Q_ACC:
            begin
                alu_a  = acc_reg;
                alu_b  = ps_rdata;
                alu_op = phase_reg ? ftrs_pkg::OP_SUB : ftrs_pkg::OP_ADD;
            end
            default:
            begin
                alu_a  = acc_reg;
                alu_b  = ps_rdata;
                alu_op = ftrs_pkg::OP_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        lo_next    = lo_reg;
        val_next   = val_reg;
        acc_next   = acc_reg;
        sum_next   = sum_reg;

        ev_we    = 1'b0;
        ev_waddr = AW'(lo_reg);
        ev_wdata = val_reg;
        ev_raddr = AW'(lo_reg);
        ps_we    = 1'b0;
        ps_waddr = k_minus1[AW-1:0];
        ps_wdata = alu_y;
        ps_raddr = k_minus1[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                ev_we    = 1'b1;
                ev_waddr = clr_reg;
                ev_wdata = '0;
                ps_we    = 1'b1;
                ps_waddr = clr_reg;
                ps_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(ELEMENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    lo_next  = index;
                    val_next = new_value;
                    acc_next = '0;
                    phase_next = 1'b0;
                    if (req_type == ftrs_pkg::REQ_SUM)
                    begin
                        k_next     = hi_sat[KW-1:0];
                        state_next = S_Q_RD;
                    end
                    else if (set_in_range)
                    begin
                        state_next = S_EV_RD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_DIFF;
            end
            S_EV_DIFF:
            begin
                // Store the new element and keep the difference for the walk.
                ev_we      = 1'b1;
                acc_next   = alu_y;
                k_next     = KW'(lo_end) + KW'(1);
                state_next = S_PS_RD;
            end
            S_PS_RD:
            begin
                state_next = S_PS_UPD;
            end
            S_PS_UPD:
            begin
                ps_we = 1'b1;
                if (up_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_up[KW-1:0];
                    state_next = S_PS_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_ACC;
            end
            S_Q_ACC:
            begin
                acc_next = alu_y;
                if (k_down != '0)
                begin
                    k_next     = k_down;
                    state_next = S_Q_RD;
                end
                else if (!phase_reg && lo_sat != '0)
                begin
                    // Advance to the low prefix, which is subtracted.
                    k_next     = lo_sat[KW-1:0];
                    phase_next = 1'b1;
                    state_next = S_Q_RD;
                end
                else
                begin
                    sum_next   = alu_y;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        val_reg <= val_next;
        acc_reg <= acc_next;
        sum_reg <= sum_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign range_sum = sum_reg;

endmodule

// ===== src/fenwick_tree_range_sum.sv =====
// Top level of the Fenwick tree range-sum block: sequencer plus the two RAMs.
// Depends on ftrs_pkg, ftrs_seq, ftrs_ram and fenwick_tree_range_sum_assert.svh.
//
//  channel   handshake          beat fields
//  --------  -----------------  ----------------------------------------
//  request   start & !busy      req_type, index, index_high, new_value
//  result    done (one cycle)   range_sum
//
// After reset the block sweeps all ELEMENTS entries of both RAMs to zero, one
// entry a cycle, with busy high. A set reads the old element, stores the new
// one, then walks the N tree nodes on the upward chain (at most
// log2(ELEMENTS)+1); a sum walks the nodes given by the set bits of the two
// prefix ends. Each node takes a RAM read and then a pass through the shared
// adder. The result beat cannot be stalled by the receiver.
module fenwick_tree_range_sum #(
    parameter int ELEMENTS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  ftrs_pkg::idx_t   index,
    input  ftrs_pkg::idx_t   index_high,
    input  ftrs_pkg::data_t  new_value,
    output logic             done,
    output ftrs_pkg::data_t  range_sum
);

`include "fenwick_tree_range_sum_assert.svh"

    localparam int AW = $clog2(ELEMENTS);

    logic              ev_we, ps_we;
    logic [AW-1:0]     ev_waddr, ev_raddr, ps_waddr, ps_raddr;
    ftrs_pkg::data_t   ev_wdata, ev_rdata, ps_wdata, ps_rdata;

    ftrs_seq #(
        .ELEMENTS (ELEMENTS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .index      (index),
        .index_high (index_high),
        .new_value  (new_value),
        .done       (done),
        .range_sum  (range_sum),
        .ev_we      (ev_we),
        .ev_waddr   (ev_waddr),
        .ev_wdata   (ev_wdata),
        .ev_raddr   (ev_raddr),
        .ev_rdata   (ev_rdata),
        .ps_we      (ps_we),
        .ps_waddr   (ps_waddr),
        .ps_wdata   (ps_wdata),
        .ps_raddr   (ps_raddr),
        .ps_rdata   (ps_rdata)
    );

    ftrs_ram #(
        .DEPTH (ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (ev_wdata),
        .raddr (ev_raddr),
        .rdata (ev_rdata)
    );

    ftrs_ram #(
        .DEPTH (ELEMENTS)
    ) u_psum_ram (
        .clk   (clk),
        .we    (ps_we),
        .waddr (ps_waddr),
        .wdata (ps_wdata),
        .raddr (ps_raddr),
        .rdata (ps_rdata)
    );

    `FTRS_ASSERT(a_done_one_cycle, clk, rst_n, done |=> !done)
    `FTRS_ASSERT(a_done_when_idle, clk, rst_n, done |-> !busy)
    `FTRS_ASSERT(a_accept_goes_busy, clk, rst_n, (start && !busy) |=> busy)
    `FTRS_ASSERT_ALWAYS(a_no_write_idle, clk, (rst_n && !busy) |-> (!ps_we && !ev_we))

endmodule
